### rtl/tcs_pkg.sv
// Package for the timelapse capture sequencer: transaction types, codes and constants.
`default_nettype none

package tcs_pkg;

   localparam int RING_DEPTH = 8;
   localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int PTR_W      = $clog2(2 * RING_DEPTH);
   localparam int OCC_W      = PTR_W + 1;

   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(2 * RING_DEPTH - 1);
   localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(RING_DEPTH);

   localparam logic [15:0] EXPO_MAX          = 16'd20000;
   localparam logic [15:0] EXPO_MIN          = 16'd1;
   localparam logic [15:0] FIXED_EXPO_LIMIT  = 16'd10;
   localparam logic [14:0] AUTO_EXPO_RESET   = 15'd100;
   localparam logic [7:0]  DIV5_RECIP        = 8'd205;

   typedef enum logic [2:0] {
      REQ_ADD   = 3'd0,
      REQ_START = 3'd1,
      REQ_TICK  = 3'd2,
      REQ_DONE  = 3'd3,
      REQ_STOP  = 3'd4
   } req_code_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [31:0]        delay_ms;
      logic [31:0]        interval_ms;
      logic [15:0]        shot_count;
      logic [15:0]        exposure_request;
      logic [2:0]         file_mode;
      logic signed [15:0] brightness_offset;
   } req_payload_type;

   typedef struct packed {
      logic        capture_fire;
      logic [15:0] exposure_value;
      logic [2:0]  capture_mode;
      logic        is_running;
      logic [15:0] shots_left;
      logic [15:0] shots_total;
      logic        queue_full;
   } rsp_payload_type;

   function automatic logic [SLOT_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
      if (p >= PTR_DEPTH) begin
         return SLOT_W'(p - PTR_DEPTH);
      end
      return SLOT_W'(p);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_incr(input logic [PTR_W-1:0] p);
      if (p == PTR_LAST) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

endpackage

`default_nettype wire

### rtl/timelapse_capture_sequencer_core.sv
// Top level of the timelapse capture sequencer: job ring, tick timing and exposure stepping.
`default_nettype none

// One transaction is taken in every cycle; busy is never raised. Each accepted
// transaction gives one result on rsp_data, marked by rsp_strobe. The input stage
// registers the request, the middle stage updates the job ring, the timer and
// the exposure state, and the result register then samples the
// head job. Results appear in request order and cannot be held off. The ring
// holds RING_DEPTH jobs; an add to a full ring is dropped and flagged.
module timelapse_capture_sequencer_core (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  tcs_pkg::req_payload_type req_data,
   output logic                     rsp_strobe,
   output tcs_pkg::rsp_payload_type rsp_data
);
   import tcs_pkg::*;

   // input stage
   req_payload_type req_ff;
   logic            req_valid_ff;

   // job ring
   logic [31:0] job_delay_ff     [RING_DEPTH];
   logic [31:0] job_delay_in     [RING_DEPTH];
   logic [31:0] job_interval_ff  [RING_DEPTH];
   logic [15:0] job_remaining_ff [RING_DEPTH];
   logic [15:0] job_remaining_in [RING_DEPTH];
   logic [15:0] job_total_ff     [RING_DEPTH];
   logic [15:0] job_total_in     [RING_DEPTH];
   logic [15:0] job_exposure_ff  [RING_DEPTH];
   logic [2:0]  job_mode_ff      [RING_DEPTH];

   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic             running_ff, running_in;
   logic             capturing_ff, capturing_in;
   logic [31:0]      elapsed_ff, elapsed_in;
   logic [14:0]      auto_ff, auto_in;
   logic signed [15:0] offset_ff, offset_in;

   // middle stage
   logic        mid_valid_ff;
   logic        fire_ff, fire_in;
   logic [15:0] expo_ff, expo_in;
   logic [2:0]  mode_ff, mode_in;
   logic        full_ff, full_in;

   // result stage
   rsp_payload_type rsp_ff;
   logic            rsp_valid_ff;

   logic [SLOT_W-1:0] head_slot, tail_slot;
   logic [OCC_W-1:0]  occ;
   logic              add_ok;
   logic [31:0]       elapsed_inc;
   logic              go;

   // automatic exposure
   logic [7:0]         step_d;
   logic signed [24:0] prod_hi;
   logic signed [25:0] num_hi;
   logic signed [19:0] num_lo;
   logic [9:0]         base_lo;
   logic [17:0]        prod_lo;
   logic [15:0]        v_raw;
   logic               num_nonpos;
   logic [15:0]        auto_value;

   assign busy = 1'b0;

   assign head_slot = ptr_slot(head_ff);
   assign tail_slot = ptr_slot(tail_ff);
   assign occ = (tail_ff >= head_ff) ? OCC_W'(tail_ff - head_ff)
                                     : OCC_W'({1'b0, tail_ff} + OCC_W'(2 * RING_DEPTH)
                                              - {1'b0, head_ff});
   assign add_ok = (occ < OCC_W'(RING_DEPTH));
   assign elapsed_inc = (elapsed_ff == 32'hFFFF_FFFF) ? elapsed_ff : elapsed_ff + 32'd1;
   assign go = (job_delay_ff[head_slot] != 32'd0) ? (elapsed_inc >= job_delay_ff[head_slot])
                                                  : (elapsed_inc >= job_interval_ff[head_slot]);

   always_comb begin
      if (auto_ff < 15'd200) begin
         step_d = 8'd2;
      end else if (auto_ff < 15'd500) begin
         step_d = 8'd5;
      end else if (auto_ff < 15'd1000) begin
         step_d = 8'd10;
      end else if (auto_ff < 15'd2000) begin
         step_d = 8'd25;
      end else if (auto_ff < 15'd5000) begin
         step_d = 8'd40;
      end else if (auto_ff < 15'd10000) begin
         step_d = 8'd80;
      end else if (auto_ff < 15'd20000) begin
         step_d = 8'd160;
      end else begin
         step_d = 8'd1;
      end
   end

   assign prod_hi = offset_ff * $signed({1'b0, step_d});
   assign num_hi  = $signed({3'b000, auto_ff, 8'h00}) - {prod_hi[24], prod_hi};
   // below 100 the divisor is 256 * 5: shift, then multiply by the reciprocal of 5
   assign num_lo  = $signed({3'b000, auto_ff[6:0], 10'h000})
                  + $signed({5'b00000, auto_ff[6:0], 8'h00})
                  - {{4{offset_ff[15]}}, offset_ff};
   assign base_lo = num_lo[17:8];
   assign prod_lo = base_lo * DIV5_RECIP;

   always_comb begin
      if (auto_ff < 15'd100) begin
         num_nonpos = (num_lo <= 20'sd0);
         v_raw      = {8'h00, prod_lo[17:10]};
      end else begin
         num_nonpos = (num_hi <= 26'sd0);
         v_raw      = num_hi[23:8];
      end
      if (num_nonpos || v_raw == 16'd0) begin
         auto_value = EXPO_MIN;
      end else if (v_raw > EXPO_MAX) begin
         auto_value = EXPO_MAX;
      end else begin
         auto_value = v_raw;
      end
   end

   always_comb begin
      job_delay_in     = job_delay_ff;
      job_remaining_in = job_remaining_ff;
      job_total_in     = job_total_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      running_in   = running_ff;
      capturing_in = capturing_ff;
      elapsed_in   = elapsed_ff;
      auto_in      = auto_ff;
      offset_in    = offset_ff;
      fire_in      = 1'b0;
      expo_in      = 16'd0;
      mode_in      = 3'd0;
      full_in      = 1'b0;
      if (req_valid_ff) begin
         unique case (req_ff.req_type)
            REQ_ADD: begin
               if (!add_ok) begin
                  full_in = 1'b1;
               end else begin
                  job_remaining_in[tail_slot] = req_ff.shot_count;
                  job_total_in[tail_slot]     = req_ff.shot_count;
                  tail_in                     = ptr_incr(tail_ff);
               end
            end
            REQ_START: begin
               running_in = 1'b1;
               elapsed_in = 32'd0;
            end
            REQ_TICK: begin
               elapsed_in = elapsed_inc;
               if (running_ff) begin
                  if (occ != '0 && job_remaining_ff[head_slot] != 16'd0) begin
                     if (!capturing_ff && go) begin
                        job_delay_in[head_slot]     = 32'd0;
                        elapsed_in                  = 32'd0;
                        job_remaining_in[head_slot] = job_remaining_ff[head_slot] - 16'd1;
                        capturing_in                = 1'b1;
                        fire_in                     = 1'b1;
                        mode_in                     = job_mode_ff[head_slot];
                        if (job_exposure_ff[head_slot] > FIXED_EXPO_LIMIT) begin
                           expo_in = job_exposure_ff[head_slot];
                        end else begin
                           expo_in = auto_value;
                           auto_in = auto_value[14:0];
                        end
                     end
                  end else if (occ > OCC_W'(1)) begin
                     head_in = ptr_incr(head_ff);
                  end else begin
                     running_in          = 1'b0;
                     head_in             = '0;
                     tail_in             = '0;
                     job_remaining_in[0] = 16'd0;
                     job_total_in[0]     = 16'd0;
                  end
               end
            end
            REQ_DONE: begin
               capturing_in = 1'b0;
               offset_in    = req_ff.brightness_offset;
            end
            REQ_STOP: begin
               running_in          = 1'b0;
               head_in             = '0;
               tail_in             = '0;
               job_remaining_in[0] = 16'd0;
               job_total_in[0]     = 16'd0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_data;
      if (req_valid_ff && req_ff.req_type == REQ_ADD && add_ok) begin
         job_interval_ff[tail_slot] <= req_ff.interval_ms;
         job_exposure_ff[tail_slot] <= req_ff.exposure_request;
         job_mode_ff[tail_slot]     <= req_ff.file_mode;
         job_delay_ff[tail_slot]    <= req_ff.delay_ms;
      end else begin
         job_delay_ff <= job_delay_in;
      end
      fire_ff <= fire_in;
      expo_ff <= expo_in;
      mode_ff <= mode_in;
      full_ff <= full_in;
      rsp_ff.capture_fire   <= fire_ff;
      rsp_ff.exposure_value <= expo_ff;
      rsp_ff.capture_mode   <= mode_ff;
      rsp_ff.is_running     <= running_ff;
      rsp_ff.shots_left     <= job_remaining_ff[head_slot];
      rsp_ff.shots_total    <= job_total_ff[head_slot];
      rsp_ff.queue_full     <= full_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff     <= 1'b0;
         mid_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         job_remaining_ff <= '{default: 16'd0};
         job_total_ff     <= '{default: 16'd0};
         head_ff          <= '0;
         tail_ff          <= '0;
         running_ff       <= 1'b0;
         capturing_ff     <= 1'b0;
         elapsed_ff       <= 32'd0;
         auto_ff          <= AUTO_EXPO_RESET;
         offset_ff        <= 16'sd0;
      end else begin
         req_valid_ff     <= start && !busy;
         mid_valid_ff     <= req_valid_ff;
         rsp_valid_ff     <= mid_valid_ff;
         job_remaining_ff <= job_remaining_in;
         job_total_ff     <= job_total_in;
         head_ff          <= head_in;
         tail_ff          <= tail_in;
         running_ff       <= running_in;
         capturing_ff     <= capturing_in;
         elapsed_ff       <= elapsed_in;
         auto_ff          <= auto_in;
         offset_ff        <= offset_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the timelapse capture sequencer core.
`timescale 1ns / 1ps

module testbench;
   import tcs_pkg::*;

   localparam int         PTR_MOD     = 2 * RING_DEPTH;
   localparam int         ITEM_TARGET = 1150;
   localparam logic [2:0] REQ_UNKNOWN = 3'd7;

   typedef struct {
      req_payload_type rq;
      bit              typed;
      rsp_payload_type want;
   } plan_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   req_payload_type req_data = '0;
   logic            rsp_strobe;
   rsp_payload_type rsp_data;

   // mirror of the job ring, timer and exposure state
   logic [31:0]        slot_delay    [RING_DEPTH];
   logic [31:0]        slot_interval [RING_DEPTH];
   logic [15:0]        slot_left     [RING_DEPTH];
   logic [15:0]        slot_total    [RING_DEPTH];
   logic [15:0]        slot_expo     [RING_DEPTH];
   logic [2:0]         slot_mode     [RING_DEPTH];
   logic [PTR_W-1:0]   rd_ptr;
   logic [PTR_W-1:0]   wr_ptr;
   logic               seq_running;
   logic               frame_pending;
   logic [31:0]        ms_count;
   logic [14:0]        auto_expo;
   logic signed [15:0] last_offset;

   rsp_payload_type due_status[$];
   plan_row_type    plan[$];
   int              errors      = 0;
   int              items_sent  = 0;
   bit              quiet_phase = 1'b0;

   timelapse_capture_sequencer_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void mirror_reset();
      for (int k = 0; k < RING_DEPTH; k++) begin
         slot_delay[k]    = '0;
         slot_interval[k] = '0;
         slot_left[k]     = '0;
         slot_total[k]    = '0;
         slot_expo[k]     = '0;
         slot_mode[k]     = '0;
      end
      rd_ptr        = '0;
      wr_ptr        = '0;
      seq_running   = 1'b0;
      frame_pending = 1'b0;
      ms_count      = '0;
      auto_expo     = AUTO_EXPO_RESET;
      last_offset   = '0;
   endfunction

   function automatic int ring_fill();
      return (int'(wr_ptr) + PTR_MOD - int'(rd_ptr)) % PTR_MOD;
   endfunction

   function automatic void empty_ring();
      seq_running   = 1'b0;
      rd_ptr        = '0;
      wr_ptr        = '0;
      slot_left[0]  = '0;
      slot_total[0] = '0;
   endfunction

   function automatic logic [15:0] step_auto_expo();
      longint a, d, den, num, v;
      a   = longint'(auto_expo);
      d   = 1;
      den = 256;
      if (a < 100) begin
         den = 256 * 5;
      end else if (a < 200) begin
         d = 2;
      end else if (a < 500) begin
         d = 5;
      end else if (a < 1000) begin
         d = 10;
      end else if (a < 2000) begin
         d = 25;
      end else if (a < 5000) begin
         d = 40;
      end else if (a < 10000) begin
         d = 80;
      end else if (a < 20000) begin
         d = 160;
      end
      num = a * den - longint'(last_offset) * d;
      v   = (num <= 0) ? 1 : num / den;
      if (v < 1) v = 1;
      if (v > longint'(EXPO_MAX)) v = longint'(EXPO_MAX);
      auto_expo = 15'(v);
      return 16'(v);
   endfunction

   function automatic rsp_payload_type sequencer_step(input req_payload_type rq);
      rsp_payload_type rs;
      int              fill, h, t;
      bit              go;
      rs   = '0;
      fill = ring_fill();
      case (rq.req_type)
         REQ_ADD: begin
            if (fill >= RING_DEPTH) begin
               rs.queue_full = 1'b1;
            end else begin
               t                = int'(wr_ptr) % RING_DEPTH;
               slot_delay[t]    = rq.delay_ms;
               slot_interval[t] = rq.interval_ms;
               slot_left[t]     = rq.shot_count;
               slot_total[t]    = rq.shot_count;
               slot_expo[t]     = rq.exposure_request;
               slot_mode[t]     = rq.file_mode;
               wr_ptr           = PTR_W'((int'(wr_ptr) + 1) % PTR_MOD);
            end
         end
         REQ_START: begin
            seq_running = 1'b1;
            ms_count    = '0;
         end
         REQ_TICK: begin
            if (ms_count != '1) ms_count++;
            if (seq_running) begin
               h = int'(rd_ptr) % RING_DEPTH;
               if (fill >= 1 && slot_left[h] != 0) begin
                  if (!frame_pending) begin
                     go = 1'b0;
                     if (slot_delay[h] != 0) begin
                        if (ms_count >= slot_delay[h]) begin
                           slot_delay[h] = '0;
                           go            = 1'b1;
                        end
                     end else if (ms_count >= slot_interval[h]) begin
                        go = 1'b1;
                     end
                     if (go) begin
                        ms_count          = '0;
                        rs.exposure_value = (slot_expo[h] > FIXED_EXPO_LIMIT) ?
                                            slot_expo[h] : step_auto_expo();
                        rs.capture_mode   = slot_mode[h];
                        rs.capture_fire   = 1'b1;
                        slot_left[h]--;
                        frame_pending     = 1'b1;
                     end
                  end
               end else if (fill > 1) begin
                  rd_ptr = PTR_W'((int'(rd_ptr) + 1) % PTR_MOD);
               end else begin
                  empty_ring();
               end
            end
         end
         REQ_DONE: begin
            frame_pending = 1'b0;
            last_offset   = rq.brightness_offset;
         end
         REQ_STOP: begin
            empty_ring();
         end
         default: begin
         end
      endcase
      h              = int'(rd_ptr) % RING_DEPTH;
      rs.is_running  = seq_running;
      rs.shots_left  = slot_left[h];
      rs.shots_total = slot_total[h];
      return rs;
   endfunction

   function automatic req_payload_type mk_req(input logic [2:0] code,
                                              input logic [31:0] dly, input logic [31:0] ivl,
                                              input logic [15:0] shots, input logic [15:0] expo,
                                              input logic [2:0] mode, input logic [15:0] ofs);
      req_payload_type rq;
      rq.req_type          = code;
      rq.delay_ms          = dly;
      rq.interval_ms       = ivl;
      rq.shot_count        = shots;
      rq.exposure_request  = expo;
      rq.file_mode         = mode;
      rq.brightness_offset = ofs;
      return rq;
   endfunction

   function automatic rsp_payload_type status(input logic fire, input logic [15:0] expo,
                                              input logic [2:0] mode, input logic run,
                                              input logic [15:0] left, input logic [15:0] total);
      rsp_payload_type rs;
      rs.capture_fire   = fire;
      rs.exposure_value = expo;
      rs.capture_mode   = mode;
      rs.is_running     = run;
      rs.shots_left     = left;
      rs.shots_total    = total;
      rs.queue_full     = 1'b0;
      return rs;
   endfunction

   function automatic void add_row(input req_payload_type rq, input bit typed = 1'b0,
                                   input rsp_payload_type want = '0);
      plan.push_back('{rq, typed, want});
   endfunction

   function automatic void load_directed_plan();
      add_row(mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0), 1, status(0, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_UNKNOWN, '1, '1, '1, '1, '1, '1), 1, status(0, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_START, 0, 0, 0, 0, 0, 0), 1, status(0, 0, 0, 1, 0, 0));
      // running with an empty ring stops at once
      add_row(mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0), 1, status(0, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_ADD, 0, 0, '1, '1, 7, '1), 1,
              status(0, 0, 0, 0, 16'hFFFF, 16'hFFFF));
      add_row(mk_req(REQ_START, 0, 0, 0, 0, 0, 0), 1,
              status(0, 0, 0, 1, 16'hFFFF, 16'hFFFF));
      add_row(mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0), 1,
              status(1, 16'hFFFF, 7, 1, 16'hFFFE, 16'hFFFF));
      // stop with a frame in flight
      add_row(mk_req(REQ_STOP, 0, 0, 0, 0, 0, 0), 1, status(0, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_DONE, 0, 0, 0, 0, 0, 16'h8000), 1, status(0, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_ADD, 2, 1, 2, 0, 5, 0), 1, status(0, 0, 0, 0, 2, 2));
      add_row(mk_req(REQ_ADD, 0, 0, 0, 10, 3, 0));
      add_row(mk_req(REQ_ADD, 1, 0, 1, 11, 6, 0));
      add_row(mk_req(REQ_ADD, '1, '1, 1, 5, 2, 0));
      add_row(mk_req(REQ_START, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_DONE, 0, 0, 0, 0, 0, 16'h7FFF));
      add_row(mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_DONE, 0, 0, 0, 0, 0, 16'h0100));
      // finished job, then a job with no shots, both skipped
      add_row(mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_DONE, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_STOP, 0, 0, 0, 0, 0, 0));
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] rand_wait();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return $urandom_range(0, 4);
      if (r < 85) return $urandom_range(5, 20);
      if (r < 95) return $urandom();
      return '1;
   endfunction

   function automatic logic [15:0] rand_shots();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return $urandom_range(1, 3);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(4, 8);
      if (r < 95) return $urandom();
      return '1;
   endfunction

   function automatic logic [15:0] rand_expo();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return $urandom_range(0, FIXED_EXPO_LIMIT);
      if (r < 80) return $urandom_range(FIXED_EXPO_LIMIT + 1, EXPO_MAX);
      return $urandom();
   endfunction

   function automatic logic [15:0] rand_offset();
      if ($urandom_range(0, 99) < 60) return 16'($urandom_range(0, 1023) - 512);
      return $urandom();
   endfunction

   task automatic issue(input req_payload_type rq, input bit typed = 1'b0,
                        input rsp_payload_type want = '0);
      rsp_payload_type mirror;
      int              gap;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      mirror = sequencer_step(rq);
      due_status.push_back(typed ? want : mirror);
      if (rq.req_type <= REQ_STOP) items_sent++;
      gap = quiet_phase ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // one sequence: optional stop, load jobs, start, then ticks with frames completing, plus noise
   task automatic run_phase();
      int jobs, steps, r;
      quiet_phase = ($urandom_range(0, 3) == 0);
      if ((seq_running || ring_fill() != 0) && $urandom_range(0, 9) != 0) begin
         issue(mk_req(REQ_STOP, 0, 0, 0, 0, 0, 0));
      end
      jobs = ($urandom_range(0, 9) == 0) ? $urandom_range(RING_DEPTH, RING_DEPTH + 2)
                                          : $urandom_range(1, 4);
      repeat (jobs) begin
         issue(mk_req(REQ_ADD, rand_wait(), rand_wait(), rand_shots(), rand_expo(),
                      $urandom(), $urandom()));
      end
      issue(mk_req(REQ_START, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom()));
      steps = 0;
      while (seq_running && steps < 80) begin
         r = $urandom_range(0, 99);
         if (r < 6) begin
            issue(mk_req($urandom_range(REQ_ADD, REQ_UNKNOWN), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom(), $urandom()));
         end else if (frame_pending && r < 45) begin
            issue(mk_req(REQ_DONE, $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), rand_offset()));
         end else begin
            issue(mk_req(REQ_TICK, $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom()));
         end
         steps++;
      end
   endtask

   task automatic check_field(input string tag, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         if (errors < 10) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, tag, want, got);
         end
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (due_status.size() == 0) begin
            if (errors < 10) $display("%0t: result with none pending: %p", $time, rsp_data);
            errors++;
         end else begin
            want = due_status.pop_front();
            check_field("capture_fire", 16'(want.capture_fire), 16'(rsp_data.capture_fire));
            check_field("exposure_value", want.exposure_value, rsp_data.exposure_value);
            check_field("capture_mode", 16'(want.capture_mode), 16'(rsp_data.capture_mode));
            check_field("is_running", 16'(want.is_running), 16'(rsp_data.is_running));
            check_field("shots_left", want.shots_left, rsp_data.shots_left);
            check_field("shots_total", want.shots_total, rsp_data.shots_total);
            check_field("queue_full", 16'(want.queue_full), 16'(rsp_data.queue_full));
         end
      end
   end

   initial begin
      mirror_reset();
      load_directed_plan();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (plan[k]) issue(plan[k].rq, plan[k].typed, plan[k].want);
      while (items_sent < ITEM_TARGET) run_phase();
      @(negedge clock);
      start <= 1'b0;
      while (due_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
